FILE: design/orbb_pkg.sv
`default_nettype none

package orbb_pkg;

    // Field widths fixed by the item formats
    localparam int OFFS_W     = 32;
    localparam int DRAWS_W    = 16;
    localparam int SLOT_W     = 6;
    localparam int USED_W     = 7;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRAWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN  = 1'd1;

    // Register reset values
    localparam logic [DRAWS_W-1:0] MAX_DRAWS_RST = 16'd1024;
    localparam logic [OFFS_W-1:0]  MAX_SPAN_RST  = 32'd134217708;

    // Item kinds carried in tuser
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_MERGE = 1'b1;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [DRAWS_W-1:0] draws;
        logic [OFFS_W-1:0]  high;
        logic [OFFS_W-1:0]  low;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

FILE: design/orbb_ram.sv
`default_nettype none

module orbb_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/offset_range_batch_binner.sv
`default_nettype none
// Offset-range batch binner.
// Input stream (s_axis): one transaction per item. tuser carries the item kind
// (add one draw, or merge an incoming batch); tdata carries the offsets and count.
// Output stream (m_axis): exactly one result transaction per input transaction,
// in order, giving the batch slot that took the item and its resulting span,
// count and the table fill afterwards.
// Configuration channel (cfg): index/data writes, always ready; write it only
// while the block is idle.
// Timing: the table sits in a single-port-read RAM and is scanned one entry per
// cycle through one shared subtract-and-compare unit. An item passes through
// its accept step, a scan over the entries and one write step; a new batch in
// the middle of the table adds a read-ahead step and a move of each later entry
// up a slot. The RAM read port sets the scan pace. The next item is taken only
// once the write step of this one is done.
// s_axis_tready is high only while no item is in work.
// Reset empties the table (fill count to zero) and restores both limits; the
// RAM contents are not cleared and need no clearing pass.
// A stalled receiver holds the result in the output register; the next item
// may be taken meanwhile and waits at its write step until the register frees.
module offset_range_batch_binner
    import orbb_pkg::*;
#(
    parameter int MAX_BATCHES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: first_offset[31:0], last_offset[63:32], draw_total[79:64]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[0]
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: slot[5:0], created[6], overflow[7], span_low[39:8],
    // span_high[71:40], held_draws[87:72], batches_used[94:88], zero[95]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_BATCHES);
    localparam int CW = $clog2(MAX_BATCHES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT,
        S_WRITE
    } t_state;

    // Sequencer and item registers
    t_state                r_state,     n_state;
    logic                  r_action,    n_action;
    logic [OFFS_W-1:0]     r_off,       n_off;
    logic [OFFS_W-1:0]     r_last,      n_last;
    logic [DRAWS_W-1:0]    r_total,     n_total;
    logic [IW-1:0]         r_idx,       n_idx;
    logic [IW-1:0]         r_sk,        n_sk;
    logic [IW-1:0]         r_pos,       n_pos;
    logic [CW-1:0]         r_used,      n_used;
    t_entry                r_wr,        n_wr;
    logic                  r_created,   n_created;
    logic                  r_ovf,       n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data,  n_out_data;
    logic [DRAWS_W-1:0]    r_max_draws, n_max_draws;
    logic [OFFS_W-1:0]     r_max_span,  n_max_span;

    // RAM port
    logic          ram_we;
    logic [IW-1:0] ram_wr_addr;
    t_entry        ram_wr_data;
    logic [IW-1:0] ram_rd_addr;
    t_entry        ram_rd_data;

    orbb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BATCHES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Shared span unit and per-entry test
    logic                 below, above, full, covers, fits, hit, at_end, empty, tbl_full;
    logic [OFFS_W-1:0]    span_a, span_b, span_diff;
    logic [OFFS_W-1:0]    mrg_low, mrg_high;
    logic [DRAWS_W:0]     mrg_sum;
    t_entry               upd;
    logic [IW-1:0]        ins_pos;
    logic                 out_free;
    logic                 in_accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        below    = r_off < ram_rd_data.low;
        above    = r_off > ram_rd_data.high;
        covers   = !below && !above;
        full     = ram_rd_data.draws >= r_max_draws;
        mrg_low  = below ? r_off : ram_rd_data.low;
        mrg_high = (r_last > ram_rd_data.high) ? r_last : ram_rd_data.high;
        mrg_sum  = {1'b0, ram_rd_data.draws} + {1'b0, r_total};

        // Pick the span under test: merged span, left extension or right extension
        if (r_action == ACT_MERGE) begin
            span_a = mrg_high;
            span_b = mrg_low;
        end else if (below) begin
            span_a = ram_rd_data.high;
            span_b = r_off;
        end else begin
            span_a = r_off;
            span_b = ram_rd_data.low;
        end
        span_diff = span_a - span_b;
        fits      = (span_a >= span_b) && (span_diff <= r_max_span);

        if (r_action == ACT_MERGE) begin
            hit       = fits && (mrg_sum <= {1'b0, r_max_draws});
            upd.low   = span_b;
            upd.high  = span_a;
            upd.draws = mrg_sum[DRAWS_W-1:0];
        end else begin
            hit       = !full && (covers || fits);
            upd.low   = below ? r_off : ram_rd_data.low;
            upd.high  = above ? r_off : ram_rd_data.high;
            upd.draws = ram_rd_data.draws + DRAWS_W'(1);
        end

        empty    = (r_used == '0);
        at_end   = (CW'(r_idx) + CW'(1)) == r_used;
        tbl_full = (r_used == CW'(MAX_BATCHES));
        ins_pos  = (empty || below) ? r_idx : IW'(r_idx + IW'(1));
    end

    // RAM addressing
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = r_sk;
        ram_wr_data = ram_rd_data;
        case (r_state)
            S_SCAN:     ram_rd_addr = IW'(r_idx + IW'(1));
            S_SHIFT_RD: ram_rd_addr = IW'(r_sk - IW'(1));
            S_SHIFT: begin
                ram_rd_addr = IW'(r_sk - IW'(2));
                ram_we      = 1'b1;
            end
            S_WRITE: begin
                ram_rd_addr = '0;
                ram_we      = out_free && !r_ovf;
                ram_wr_addr = r_pos;
                ram_wr_data = r_wr;
            end
            default:    ram_rd_addr = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_off       = r_off;
        n_last      = r_last;
        n_total     = r_total;
        n_idx       = r_idx;
        n_sk        = r_sk;
        n_pos       = r_pos;
        n_used      = r_used;
        n_wr        = r_wr;
        n_created   = r_created;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_max_draws = r_max_draws;
        n_max_span  = r_max_span;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_DRAWS: n_max_draws = i_cfg_data[DRAWS_W-1:0];
                REG_MAX_SPAN:  n_max_span  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_action = s_axis_tuser;
                    n_off    = s_axis_tdata[31:0];
                    n_last   = s_axis_tdata[63:32];
                    n_total  = s_axis_tdata[79:64];
                    n_idx    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!empty && hit) begin
                    // Join this batch
                    n_pos     = r_idx;
                    n_wr      = upd;
                    n_created = 1'b0;
                    n_ovf     = 1'b0;
                    n_state   = S_WRITE;
                end else if (empty || below || at_end) begin
                    // New batch at or just after the scan position, or drop when full
                    n_pos        = ins_pos;
                    n_wr.low     = r_off;
                    n_wr.high    = (r_action == ACT_MERGE) ? r_last : r_off;
                    n_wr.draws   = (r_action == ACT_MERGE) ? r_total : DRAWS_W'(1);
                    n_created    = !tbl_full;
                    n_ovf        = tbl_full;
                    n_sk         = r_used[IW-1:0];
                    if (tbl_full || CW'(ins_pos) == r_used) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    n_idx = IW'(r_idx + IW'(1));
                end
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Move entry sk-1 up into sk; stop once the gap reaches pos
                if (IW'(r_sk - IW'(1)) == r_pos) begin
                    n_state = S_WRITE;
                end else begin
                    n_sk = IW'(r_sk - IW'(1));
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_used      = r_used + CW'(r_created);
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, USED_W'(n_used),
                                   r_ovf ? {DRAWS_W{1'b0}} : r_wr.draws,
                                   r_ovf ? {OFFS_W{1'b0}} : r_wr.high,
                                   r_ovf ? {OFFS_W{1'b0}} : r_wr.low,
                                   r_ovf, r_created,
                                   r_ovf ? {SLOT_W{1'b0}} : SLOT_W'(r_pos)};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_max_draws <= MAX_DRAWS_RST;
            r_max_span  <= MAX_SPAN_RST;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_max_draws <= n_max_draws;
            r_max_span  <= n_max_span;
        end
        r_action   <= n_action;
        r_off      <= n_off;
        r_last     <= n_last;
        r_total    <= n_total;
        r_idx      <= n_idx;
        r_sk       <= n_sk;
        r_pos      <= n_pos;
        r_wr       <= n_wr;
        r_created  <= n_created;
        r_ovf      <= n_ovf;
        r_out_data <= n_out_data;
    end

    // Fill count never passes the table depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_BATCHES))
        else $error("batch count beyond table depth");

    // An overflow result only ever stands with a full table
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[7]) |-> (r_used == CW'(MAX_BATCHES)))
        else $error("overflow reported with room in the table");

    // A new batch raises the fill count by one
    a_created_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && out_free && r_created) |=>
            (r_used == $past(r_used) + CW'(1)))
        else $error("fill count not advanced on insert");

    // Busy after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire
